// ===== hdl/tsaq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsaq_pkg
// shared types and constants of the touch sample averaging and qualify block
// ----------------------------------------------------------------------------
package tsaq_pkg;

   // field widths of the stream payloads
   localparam int INPUT_W     = 12;
   localparam int POS_W       = 13;
   localparam int PRES_W      = 11;
   localparam int LIMIT_W     = 13;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_INDEX_W = 2;

   // register indexes of the configuration channel
   localparam logic [CSR_INDEX_W-1:0] CSR_COORD_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_SPREAD_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_SPREAD_LIMIT = 2'd2;

   // register reset values
   localparam logic [LIMIT_W-1:0] COORD_LIMIT_RESET  = 13'd910;
   localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RESET = 13'd100;

   // reported pressure of a qualified touch
   localparam logic [PRES_W-1:0] TOUCH_PRESSURE = 11'd1024;

   typedef struct packed {
      logic [LIMIT_W-1:0] coord_limit;
      logic [LIMIT_W-1:0] x_spread_limit;
      logic [LIMIT_W-1:0] y_spread_limit;
   } tsaq_limits_type;

endpackage

// ===== hdl/tsaq_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsaq_accum
// input register, per-axis sum and min/max accumulation, round snapshot
// ----------------------------------------------------------------------------
module tsaq_accum import tsaq_pkg::*; #(
   parameter int NUM_ROUNDS = 10,
   parameter int ADC_BITS   = 12,
   parameter int VAL_W      = 13,
   parameter int TOT_W      = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_DATA_W-1:0] req_data,
   output logic                  snap_valid,
   input  logic                  snap_ready,
   output logic [TOT_W-1:0]      snap_x_total,
   output logic [TOT_W-1:0]      snap_y_total,
   output logic [VAL_W-1:0]      snap_x_low,
   output logic [VAL_W-1:0]      snap_x_high,
   output logic [VAL_W-1:0]      snap_y_low,
   output logic [VAL_W-1:0]      snap_y_high
);

   localparam int RND_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
   localparam int CMP_W = (VAL_W > INPUT_W) ? VAL_W : INPUT_W;
   localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(NUM_ROUNDS - 1);
   localparam logic [CMP_W-1:0] TOP_CODE   = CMP_W'((64'd1 << ADC_BITS) - 64'd1);
   localparam logic [VAL_W-1:0] LOW_RESET  = VAL_W'((64'd1 << ADC_BITS) - 64'd1);
   localparam logic [VAL_W-1:0] FULL_SCALE = VAL_W'(64'd1 << ADC_BITS);

   function automatic logic [VAL_W-1:0] clamp(input logic [INPUT_W-1:0] raw);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(raw);
      return (wide > TOP_CODE) ? VAL_W'(TOP_CODE) : VAL_W'(wide);
   endfunction

   function automatic logic [VAL_W-1:0] min3(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b,
                                            input logic [VAL_W-1:0] c);
      logic [VAL_W-1:0] m;
      m = (b < a) ? b : a;
      return (c < m) ? c : m;
   endfunction

   function automatic logic [VAL_W-1:0] max3(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b,
                                            input logic [VAL_W-1:0] c);
      logic [VAL_W-1:0] m;
      m = (b > a) ? b : a;
      return (c > m) ? c : m;
   endfunction

   logic                  in_valid_ff, in_valid_in;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic [RND_W-1:0]      round_ff, round_in;
   logic [TOT_W-1:0]      x_total_ff, x_total_in, y_total_ff, y_total_in;
   logic [VAL_W-1:0]      x_low_ff, x_low_in, x_high_ff, x_high_in;
   logic [VAL_W-1:0]      y_low_ff, y_low_in, y_high_ff, y_high_in;
   logic                  snap_valid_ff, snap_valid_in;
   logic [TOT_W-1:0]      snap_x_total_ff, snap_y_total_ff;
   logic [VAL_W-1:0]      snap_x_low_ff, snap_x_high_ff, snap_y_low_ff, snap_y_high_ff;

   logic                  in_last, snap_free, in_move;
   logic [VAL_W-1:0]      xf, yf, xr, yr;
   logic [TOT_W-1:0]      x_sum, y_sum;
   logic [VAL_W-1:0]      x_lo, x_hi, y_lo, y_hi;

   // readings of the held round, reversed ones mirrored about full scale
   assign xf = clamp(in_data_ff[0*INPUT_W +: INPUT_W]);
   assign yf = clamp(in_data_ff[1*INPUT_W +: INPUT_W]);
   assign xr = FULL_SCALE - clamp(in_data_ff[2*INPUT_W +: INPUT_W]);
   assign yr = FULL_SCALE - clamp(in_data_ff[3*INPUT_W +: INPUT_W]);

   assign x_sum = x_total_ff + TOT_W'(xf) + TOT_W'(xr);
   assign y_sum = y_total_ff + TOT_W'(yf) + TOT_W'(yr);
   assign x_lo  = min3(x_low_ff, xf, xr);
   assign x_hi  = max3(x_high_ff, xf, xr);
   assign y_lo  = min3(y_low_ff, yf, yr);
   assign y_hi  = max3(y_high_ff, yf, yr);

   // a closing round waits only when the snapshot cannot take it
   assign in_last   = (round_ff == LAST_ROUND);
   assign snap_free = !snap_valid_ff || snap_ready;
   assign in_move   = in_valid_ff && (!in_last || snap_free);
   assign req_ready = !in_valid_ff || in_move;

   always_comb begin
      in_valid_in   = req_ready ? req_valid : in_valid_ff;
      round_in      = round_ff;
      x_total_in    = x_total_ff;
      y_total_in    = y_total_ff;
      x_low_in      = x_low_ff;
      x_high_in     = x_high_ff;
      y_low_in      = y_low_ff;
      y_high_in     = y_high_ff;
      snap_valid_in = snap_ready ? 1'b0 : snap_valid_ff;
      if (in_move) begin
         if (in_last) begin
            round_in      = '0;
            x_total_in    = '0;
            y_total_in    = '0;
            x_low_in      = LOW_RESET;
            x_high_in     = '0;
            y_low_in      = LOW_RESET;
            y_high_in     = '0;
            snap_valid_in = 1'b1;
         end else begin
            round_in      = round_ff + RND_W'(1);
            x_total_in    = x_sum;
            y_total_in    = y_sum;
            x_low_in      = x_lo;
            x_high_in     = x_hi;
            y_low_in      = y_lo;
            y_high_in     = y_hi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         round_ff      <= '0;
         x_total_ff    <= '0;
         y_total_ff    <= '0;
         x_low_ff      <= LOW_RESET;
         x_high_ff     <= '0;
         y_low_ff      <= LOW_RESET;
         y_high_ff     <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         round_ff      <= round_in;
         x_total_ff    <= x_total_in;
         y_total_ff    <= y_total_in;
         x_low_ff      <= x_low_in;
         x_high_ff     <= x_high_in;
         y_low_ff      <= y_low_in;
         y_high_ff     <= y_high_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (in_move && in_last) begin
         snap_x_total_ff <= x_sum;
         snap_y_total_ff <= y_sum;
         snap_x_low_ff   <= x_lo;
         snap_x_high_ff  <= x_hi;
         snap_y_low_ff   <= y_lo;
         snap_y_high_ff  <= y_hi;
      end
   end

   assign snap_valid   = snap_valid_ff;
   assign snap_x_total = snap_x_total_ff;
   assign snap_y_total = snap_y_total_ff;
   assign snap_x_low   = snap_x_low_ff;
   assign snap_x_high  = snap_x_high_ff;
   assign snap_y_low   = snap_y_low_ff;
   assign snap_y_high  = snap_y_high_ff;

endmodule

// ===== hdl/tsaq_qualify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsaq_qualify
// averaging by reciprocal multiply, touch qualification, result register
// ----------------------------------------------------------------------------
module tsaq_qualify import tsaq_pkg::*; #(
   parameter int NUM_ROUNDS = 10,
   parameter int ADC_BITS   = 12,
   parameter int VAL_W      = 13,
   parameter int TOT_W      = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tsaq_limits_type       limits,
   input  logic                  snap_valid,
   output logic                  snap_ready,
   input  logic [TOT_W-1:0]      snap_x_total,
   input  logic [TOT_W-1:0]      snap_y_total,
   input  logic [VAL_W-1:0]      snap_x_low,
   input  logic [VAL_W-1:0]      snap_x_high,
   input  logic [VAL_W-1:0]      snap_y_low,
   input  logic [VAL_W-1:0]      snap_y_high,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RSP_DATA_W-1:0] rsp_data
);

   // exact floor division: t * ceil(2^SH / DIV) >> SH for every t below 2^TOT_W
   localparam int DIVISOR = 2 * NUM_ROUNDS;
   localparam int DIV_LOG = $clog2(DIVISOR);
   localparam int SH      = TOT_W + DIV_LOG;
   localparam int MW      = TOT_W + 2;
   localparam int PW      = TOT_W + MW;
   localparam int AVG_W   = VAL_W;
   localparam int CW      = (AVG_W > LIMIT_W) ? AVG_W : LIMIT_W;
   localparam int PAD_W   = RSP_DATA_W - 2 * POS_W - PRES_W;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
   localparam logic [AVG_W-1:0] FULL_SCALE = AVG_W'(64'd1 << ADC_BITS);

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  x_pos_ff, y_pos_ff;
   logic [PRES_W-1:0] pres_ff;

   logic              out_free;
   logic [PW-1:0]     x_prod, y_prod;
   logic [AVG_W-1:0]  x_avg, y_avg, y_mirror;
   logic [VAL_W-1:0]  x_spread, y_spread;
   logic              touched;

   assign x_prod = PW'(snap_x_total) * PW'(RECIP);
   assign y_prod = PW'(snap_y_total) * PW'(RECIP);
   assign x_avg  = x_prod[SH +: AVG_W];
   assign y_avg  = y_prod[SH +: AVG_W];

   assign y_mirror = FULL_SCALE - y_avg;

   assign x_spread = (snap_x_high >= snap_x_low) ? (snap_x_high - snap_x_low) : '0;
   assign y_spread = (snap_y_high >= snap_y_low) ? (snap_y_high - snap_y_low) : '0;

   assign touched = (CW'(x_avg) < CW'(limits.coord_limit)) &&
                    (CW'(y_avg) < CW'(limits.coord_limit)) &&
                    (CW'(x_spread) < CW'(limits.x_spread_limit)) &&
                    (CW'(y_spread) < CW'(limits.y_spread_limit));

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign snap_ready   = out_free;
   assign rsp_valid_in = out_free ? snap_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_valid && out_free) begin
         x_pos_ff <= POS_W'(x_avg);
         y_pos_ff <= POS_W'(y_mirror);
         pres_ff  <= touched ? TOUCH_PRESSURE : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = {{PAD_W{1'b0}}, pres_ff, y_pos_ff, x_pos_ff};

endmodule

// ===== hdl/touch_sample_average_and_qualify_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_average_and_qualify_top
// averages resistive touch panel rounds and qualifies a touch
// ----------------------------------------------------------------------------
// usage
//  - req channel: one transaction per measurement round carrying forward and
//    reversed X/Y readings; reversed readings are mirrored as full scale minus
//    value before they join the per-axis sums and min/max
//  - after NUM_ROUNDS rounds one rsp transaction carries the averaged X, the
//    mirrored averaged Y and the pressure (1024 when touch qualifies, else 0);
//    rounds that do not close a group produce no rsp transaction
//  - csr channel: always ready, writes coord_limit, x_spread_limit and
//    y_spread_limit by index; unknown indexes are dropped
//  - throughput: one round per clock unless an rsp stall backs up to the input
//    register; the accumulate stage and the divide / qualify stage are registered
//  - result path: rsp_tvalid rises once the closing round's transaction has
//    passed the input register, snapshot register and result register
//  - reset clears the accumulators, the round count, all valid flags and sets
//    the limits to 910 / 100 / 100
//  - rsp stall: the result register holds; rounds keep flowing until one group
//    waits in the result register and a second in the snapshot register, then
//    the next closing round holds in the input register and req_tready drops
// ----------------------------------------------------------------------------
module touch_sample_average_and_qualify_top import tsaq_pkg::*; #(
   parameter int NUM_ROUNDS = 10,
   parameter int ADC_BITS   = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // round channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // x_forward, y_forward, x_reverse, y_reverse
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // x_position, y_position, pressure, zero pad
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]     csr_data
);

   // value width holds full scale itself (mirror of a zero reading)
   localparam int VAL_W = ADC_BITS + 1;
   localparam int TOT_W = $clog2(2 * NUM_ROUNDS * (2 ** ADC_BITS) + 1);

   tsaq_limits_type  limits_ff, limits_in;

   logic             snap_valid, snap_ready;
   logic [TOT_W-1:0] snap_x_total, snap_y_total;
   logic [VAL_W-1:0] snap_x_low, snap_x_high, snap_y_low, snap_y_high;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COORD_LIMIT:    limits_in.coord_limit    = csr_data;
            CSR_X_SPREAD_LIMIT: limits_in.x_spread_limit = csr_data;
            CSR_Y_SPREAD_LIMIT: limits_in.y_spread_limit = csr_data;
            default:            limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.coord_limit    <= COORD_LIMIT_RESET;
         limits_ff.x_spread_limit <= SPREAD_LIMIT_RESET;
         limits_ff.y_spread_limit <= SPREAD_LIMIT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   // round accumulation, hands each finished group to the snapshot register
   tsaq_accum #(
      .NUM_ROUNDS (NUM_ROUNDS),
      .ADC_BITS   (ADC_BITS),
      .VAL_W      (VAL_W),
      .TOT_W      (TOT_W)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_data     (req_tdata),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap_x_total (snap_x_total),
      .snap_y_total (snap_y_total),
      .snap_x_low   (snap_x_low),
      .snap_x_high  (snap_x_high),
      .snap_y_low   (snap_y_low),
      .snap_y_high  (snap_y_high)
   );

   // averaging, qualification and result register
   tsaq_qualify #(
      .NUM_ROUNDS (NUM_ROUNDS),
      .ADC_BITS   (ADC_BITS),
      .VAL_W      (VAL_W),
      .TOT_W      (TOT_W)
   ) u_qualify (
      .clock        (clock),
      .reset        (reset),
      .limits       (limits_ff),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap_x_total (snap_x_total),
      .snap_y_total (snap_y_total),
      .snap_x_low   (snap_x_low),
      .snap_x_high  (snap_x_high),
      .snap_y_low   (snap_y_low),
      .snap_y_high  (snap_y_high),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_data     (rsp_tdata)
   );

`ifndef SYNTHESIS
   // a finished group waiting for the result stage keeps its totals
   a_snap_hold: assert property (@(posedge clock) disable iff (reset)
      snap_valid && !snap_ready |=> snap_valid && $stable(snap_x_total)
                                    && $stable(snap_y_total))
      else $error("snapshot changed while waiting");

   // a group's min never exceeds its max
   a_snap_order: assert property (@(posedge clock) disable iff (reset)
      snap_valid |-> snap_x_low <= snap_x_high && snap_y_low <= snap_y_high)
      else $error("snapshot min above max");

   // pressure only takes its two legal values
   a_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[36:26] == '0 || rsp_tdata[36:26] == TOUCH_PRESSURE)
      else $error("illegal pressure value");

   // nothing is pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !snap_valid)
      else $error("valid flag survived reset");
`endif

endmodule
